FILE: rtl/core/ibr_pkg.sv
// Shared types and constants for the 8x8 intra block reconstruction core.
package ibr_pkg;

  // Block geometry (fixed 8x8 luma blocks)
  localparam int unsigned BlockSize     = 8;
  localparam int unsigned MaxBlocksDown = 64;

  // Configuration register indexes
  localparam logic CfgBlocksAcross = 1'b0;
  localparam logic CfgBlocksDown   = 1'b1;

  // Configuration reset values
  localparam logic [6:0] BlocksAcrossReset = 7'd44;
  localparam logic [6:0] BlocksDownReset   = 7'd36;

  // Missing neighbor value, and the sum of eight of them
  localparam logic [7:0]  MissingNeighbor = 8'd128;
  localparam logic [10:0] MissingSum      = 11'd1024;

  // Prediction modes as carried in tuser on a block's first pixel
  typedef enum logic [1:0] {
    MODE_DC      = 2'd0,
    MODE_VERT    = 2'd1,
    MODE_HORZ    = 2'd2,
    MODE_INVALID = 2'd3
  } mode_e;

  // Control state: DC preparation before a block, then pixel run
  typedef enum logic [1:0] {
    ST_PREP = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

endpackage

FILE: rtl/core/intra_block_reconstruct.sv
// Top level of the 8x8 intra block reconstruction core (DC, vertical, horizontal).
// Pixels pass through the compute stage register and the output register to the master side.
// Throughput: one pixel per cycle inside a block while the master side accepts; between blocks
// the compute stage drains, then the above row is summed for DC (not on the top block line). Reset
// clears counters, mode and DC value, sets blocks_across 44 and blocks_down 36; the line memory
// and left column are not cleared.
module intra_block_reconstruct #(
  parameter int unsigned MAX_BLOCKS_ACROSS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Residual input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] residual
  input  logic [1:0] s_axis_tuser,   // [1:0] cmd
  // Reconstructed pixel stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] pixel
  output logic       m_axis_tlast,   // block_last
  output logic [1:0] m_axis_tuser,   // [0] mode_error, [1] frame_last
  // Configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  localparam int unsigned ColW   = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;
  localparam int unsigned AddrW  = ColW + 3;
  localparam int unsigned MemDepth = MAX_BLOCKS_ACROSS * ibr_pkg::BlockSize;
  localparam int unsigned CmpW   = ColW + 8;

  // Configuration registers
  logic [6:0] blocks_across_q, blocks_down_q;

  // Control state
  ibr_pkg::state_e state_q, state_d;
  logic [5:0]      pixel_index_q;
  logic [ColW-1:0] block_column_q;
  logic [5:0]      block_line_q;
  ibr_pkg::mode_e  block_mode_q;
  logic [7:0]      dc_value_q;
  logic [3:0]      prep_cnt_q;
  logic [10:0]     above_acc_q;
  logic [10:0]     left_acc_q;

  // Line memory and left column
  logic [7:0]       above_mem [MemDepth];
  logic [7:0]       rd_data_q;
  logic [7:0]       left_q [ibr_pkg::BlockSize];

  // Compute stage
  logic             s1_valid_q;
  logic [7:0]       s1_residual_q;
  logic [5:0]       s1_index_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_has_above_q, s1_has_left_q;
  logic             s1_blk_last_q, s1_frm_last_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_pixel_q;
  logic       out_err_q, out_blast_q, out_flast_q;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_across_q <= ibr_pkg::BlocksAcrossReset;
      blocks_down_q   <= ibr_pkg::BlocksDownReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ibr_pkg::CfgBlocksAcross) blocks_across_q <= cfg_data_i;
      else blocks_down_q <= cfg_data_i;
    end
  end

  // Effective picture size, clamped to the supported range
  logic [CmpW-1:0] across_ext, across_eff, col_next_ext;
  logic [6:0]      down_eff, line_next;
  always_comb begin
    across_ext = CmpW'(blocks_across_q);
    if (across_ext == '0) across_eff = CmpW'(1);
    else if (across_ext > CmpW'(MAX_BLOCKS_ACROSS)) across_eff = CmpW'(MAX_BLOCKS_ACROSS);
    else across_eff = across_ext;
    if (blocks_down_q == 7'd0) down_eff = 7'd1;
    else if (blocks_down_q > 7'(ibr_pkg::MaxBlocksDown)) down_eff = 7'(ibr_pkg::MaxBlocksDown);
    else down_eff = blocks_down_q;
    col_next_ext = CmpW'(block_column_q) + CmpW'(1);
    line_next    = {1'b0, block_line_q} + 7'd1;
  end

  // Handshake between stages
  logic s1_fire, in_fire;
  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ibr_pkg::ST_RUN) && (!s1_valid_q || s1_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Position flags of the pixel being accepted
  logic has_above, has_left, blk_last, col_end, line_end;
  assign has_above = block_line_q != 6'd0;
  assign has_left  = block_column_q != '0;
  assign blk_last  = pixel_index_q == 6'd63;
  assign col_end   = col_next_ext >= across_eff;
  assign line_end  = line_next >= down_eff;

  // Prediction and reconstruction in the compute stage
  logic [2:0] s1_row, s1_col;
  logic [7:0] pred, pix;
  logic       pix_err;
  assign s1_row = s1_index_q[5:3];
  assign s1_col = s1_index_q[2:0];

  always_comb begin
    case (block_mode_q)
      ibr_pkg::MODE_DC:   pred = dc_value_q;
      ibr_pkg::MODE_VERT: pred = s1_has_above_q ? rd_data_q : ibr_pkg::MissingNeighbor;
      ibr_pkg::MODE_HORZ: pred = s1_has_left_q ? left_q[s1_row] : ibr_pkg::MissingNeighbor;
      default:            pred = 8'd0;
    endcase
    pix_err = block_mode_q == ibr_pkg::MODE_INVALID;
    pix     = pix_err ? 8'd0 : s1_residual_q + pred;
  end

  // DC preparation: sum of the above row plus the left column sum, MissingSum for a missing side
  logic             prep_active, prep_done, prep_rd;
  logic [10:0]      left_term;
  logic [11:0]      dc_sum;
  always_comb begin
    prep_active = (state_q == ibr_pkg::ST_PREP) && !s1_valid_q;
    prep_rd     = prep_active && has_above && (prep_cnt_q < 4'd8);
    prep_done   = prep_active && (!has_above || (prep_cnt_q == 4'd8));
    left_term   = has_left ? left_acc_q : ibr_pkg::MissingSum;
    if (has_above) dc_sum = {1'b0, above_acc_q} + 12'(rd_data_q) + {1'b0, left_term};
    else dc_sum = {1'b0, ibr_pkg::MissingSum} + {1'b0, left_term};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ibr_pkg::ST_PREP: if (prep_done) state_d = ibr_pkg::ST_RUN;
      ibr_pkg::ST_RUN:  if (in_fire && blk_last) state_d = ibr_pkg::ST_PREP;
      default:          state_d = ibr_pkg::ST_PREP;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ibr_pkg::ST_PREP;
      pixel_index_q  <= '0;
      block_column_q <= '0;
      block_line_q   <= '0;
      block_mode_q   <= ibr_pkg::MODE_DC;
      dc_value_q     <= '0;
      prep_cnt_q     <= '0;
      above_acc_q    <= '0;
      left_acc_q     <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      // Preparation sequencing
      if (prep_done) begin
        dc_value_q  <= dc_sum[11:4];
        prep_cnt_q  <= '0;
        above_acc_q <= '0;
        left_acc_q  <= '0;
      end else if (prep_active) begin
        prep_cnt_q <= prep_cnt_q + 4'd1;
        if (prep_cnt_q != 4'd0) above_acc_q <= above_acc_q + 11'(rd_data_q);
      end

      // Block position counters
      if (in_fire) begin
        if (pixel_index_q == 6'd0) block_mode_q <= ibr_pkg::mode_e'(s_axis_tuser);
        if (blk_last) begin
          pixel_index_q <= '0;
          if (col_end) begin
            block_column_q <= '0;
            block_line_q   <= line_end ? 6'd0 : line_next[5:0];
          end else begin
            block_column_q <= block_column_q + ColW'(1);
          end
        end else begin
          pixel_index_q <= pixel_index_q + 6'd1;
        end
      end

      // Right column pixels feed the next block's left sum
      if (s1_fire && (s1_col == 3'd7)) left_acc_q <= left_acc_q + 11'(pix);

      if (in_fire) s1_valid_q <= 1'b1;
      else if (s1_fire) s1_valid_q <= 1'b0;

      if (s1_fire) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Line memory: one read port shared by pixels and preparation, one write port
  logic [AddrW-1:0] rd_addr;
  assign rd_addr = prep_rd ? {block_column_q, prep_cnt_q[2:0]}
                           : {block_column_q, pixel_index_q[2:0]};

  always_ff @(posedge clk_i) begin
    if (in_fire || prep_rd) rd_data_q <= above_mem[rd_addr];
    if (s1_fire && (s1_row == 3'd7)) above_mem[s1_addr_q] <= pix;
  end

  // Payload registers of the compute and output stages
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_residual_q  <= s_axis_tdata;
      s1_index_q     <= pixel_index_q;
      s1_addr_q      <= {block_column_q, pixel_index_q[2:0]};
      s1_has_above_q <= has_above;
      s1_has_left_q  <= has_left;
      s1_blk_last_q  <= blk_last;
      s1_frm_last_q  <= blk_last && col_end && line_end;
    end
    if (s1_fire) begin
      if (s1_col == 3'd7) left_q[s1_row] <= pix;
      out_pixel_q <= pix;
      out_err_q   <= pix_err;
      out_blast_q <= s1_blk_last_q;
      out_flast_q <= s1_frm_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pixel_q;
  assign m_axis_tlast  = out_blast_q;
  assign m_axis_tuser  = {out_flast_q, out_err_q};

endmodule

FILE: sim/intra_block_reconstruct_checker.sv
// Checker for intra_block_reconstruct: watches all channels, predicts each pixel, compares.
`timescale 1ns / 100ps
module intra_block_reconstruct_checker #(
  parameter int unsigned MAX_BLOCKS_ACROSS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] residual
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] pixel
  input  logic        m_axis_tlast,   // block_last
  input  logic [1:0]  m_axis_tuser,   // [0] mode_error, [1] frame_last
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] pixel;
    logic       mode_error;
    logic       block_last;
    logic       frame_last;
  } recon_pixel_t;

  // Predictor state
  logic [7:0]     above_row [MAX_BLOCKS_ACROSS*ibr_pkg::BlockSize];
  logic [7:0]     left_col  [ibr_pkg::BlockSize];
  logic [7:0]     dc_q;
  ibr_pkg::mode_e mode_q;
  int unsigned    pix_q, col_q, line_q;
  logic [6:0]     across_q, down_q;
  recon_pixel_t   pixel_q [$];
  recon_pixel_t   want;

  function automatic int unsigned clamp_blocks(input logic [6:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count_o++;
    $display("%0t ERROR: %s", $time, msg);
  endtask

  // Rebuild one pixel and queue the expected transaction
  task automatic reconstruct(input logic [1:0] cmd, input logic [7:0] residual);
    int unsigned  across, down, row, px_col, sum;
    logic         has_above, has_left;
    logic [7:0]   pred;
    recon_pixel_t r;
    across    = clamp_blocks(across_q, MAX_BLOCKS_ACROSS);
    down      = clamp_blocks(down_q, ibr_pkg::MaxBlocksDown);
    has_above = (line_q != 0);
    has_left  = (col_q != 0);

    // First pixel: latch mode, form DC from neighbors
    if (pix_q == 0) begin
      sum    = 0;
      mode_q = ibr_pkg::mode_e'(cmd);
      for (int k = 0; k < ibr_pkg::BlockSize; k++) begin
        sum += has_above ? above_row[col_q*ibr_pkg::BlockSize + k] : ibr_pkg::MissingNeighbor;
        sum += has_left ? left_col[k] : ibr_pkg::MissingNeighbor;
      end
      dc_q = 8'(sum >> 4);
    end

    row    = pix_q >> 3;
    px_col = pix_q & 7;
    case (mode_q)
      ibr_pkg::MODE_DC:   pred = dc_q;
      ibr_pkg::MODE_VERT: pred = has_above ? above_row[col_q*ibr_pkg::BlockSize + px_col]
                                           : ibr_pkg::MissingNeighbor;
      ibr_pkg::MODE_HORZ: pred = has_left ? left_col[row] : ibr_pkg::MissingNeighbor;
      default:            pred = '0;
    endcase

    r.mode_error = (mode_q == ibr_pkg::MODE_INVALID);
    r.pixel      = r.mode_error ? 8'd0 : 8'(residual + pred);

    // Bottom row feeds the next block line, right column the next block
    if (row == 7) above_row[col_q*ibr_pkg::BlockSize + px_col] = r.pixel;
    if (px_col == 7) left_col[row] = r.pixel;

    r.block_last = (pix_q == 63);
    r.frame_last = r.block_last && (col_q + 1 >= across) && (line_q + 1 >= down);

    // Walk the picture in raster order
    if (r.block_last) begin
      pix_q = 0;
      if (col_q + 1 >= across) begin
        col_q  = 0;
        line_q = (line_q + 1 >= down) ? 0 : line_q + 1;
      end else begin
        col_q++;
      end
    end else begin
      pix_q++;
    end
    pixel_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q             = '0;
      mode_q           = ibr_pkg::MODE_DC;
      pix_q            = 0;
      col_q            = 0;
      line_q           = 0;
      across_q         = ibr_pkg::BlocksAcrossReset;
      down_q           = ibr_pkg::BlocksDownReset;
      mismatch_count_o = 0;
      pixel_q.delete();
      pending_o <= 0;
    end else begin
      // Output transaction against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %0d", m_axis_tdata));
        end else begin
          want = pixel_q.pop_front();
          if (m_axis_tdata !== want.pixel)
            report_mismatch($sformatf("pixel got %0d expected %0d",
                                      m_axis_tdata, want.pixel));
          if (m_axis_tuser[0] !== want.mode_error)
            report_mismatch($sformatf("mode_error got %b expected %b",
                                      m_axis_tuser[0], want.mode_error));
          if (m_axis_tlast !== want.block_last)
            report_mismatch($sformatf("block_last got %b expected %b",
                                      m_axis_tlast, want.block_last));
          if (m_axis_tuser[1] !== want.frame_last)
            report_mismatch($sformatf("frame_last got %b expected %b",
                                      m_axis_tuser[1], want.frame_last));
        end
      end

      // Register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ibr_pkg::CfgBlocksAcross: across_q = cfg_data_i;
          ibr_pkg::CfgBlocksDown:   down_q   = cfg_data_i;
          default:                  ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) reconstruct(s_axis_tuser, s_axis_tdata);
      pending_o <= pixel_q.size();
    end
  end

endmodule

FILE: sim/intra_block_reconstruct_tb.sv
// Testbench top for intra_block_reconstruct: clock, reset, residual stimulus and verdict.
`timescale 1ns / 100ps
module intra_block_reconstruct_tb;

  localparam int unsigned MaxAcross    = 64;
  localparam int unsigned RandomPixels = 1100;
  localparam int unsigned IdlePercent  = 32;
  localparam int unsigned DrainCycles  = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [6:0]  cfg_data_i;
  int unsigned mismatches;
  int unsigned pending;
  logic        idle_en;

  // Picture position as seen by the sender, used to keep register writes legal
  int unsigned          trk_pix, trk_col, trk_line;
  logic [6:0]           across_cfg, down_cfg;
  logic [MaxAcross-1:0] col_written;

  intra_block_reconstruct #(
    .MAX_BLOCKS_ACROSS(MaxAcross)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  intra_block_reconstruct_checker #(
    .MAX_BLOCKS_ACROSS(MaxAcross)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Random back-pressure on the pixel output
  always @(posedge clk_i) begin
    m_axis_tready <= !(idle_en && $urandom_range(99) < IdlePercent);
  end

  initial begin
    #2ms;
    $display("intra_block_reconstruct test failed");
    $finish;
  end

  function automatic int unsigned clamp_blocks(input logic [6:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Widening the picture on a lower block line must not reach unwritten columns
  function automatic bit across_ok(input logic [6:0] v);
    if (trk_line == 0) return 1'b1;
    for (int c = 0; c < clamp_blocks(v, MaxAcross); c++)
      if (!col_written[c]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_pixel(input logic [1:0] cmd, input logic [7:0] residual);
    while (idle_en && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= residual;
    do @(posedge clk_i); while (!s_axis_tready);

    // Follow the raster walk
    if (trk_pix == 63) begin
      col_written[trk_col] = 1'b1;
      trk_pix = 0;
      if (trk_col + 1 >= clamp_blocks(across_cfg, MaxAcross)) begin
        trk_col  = 0;
        trk_line = (trk_line + 1 >= clamp_blocks(down_cfg, ibr_pkg::MaxBlocksDown)) ?
                   0 : trk_line + 1;
      end else begin
        trk_col++;
      end
    end else begin
      trk_pix++;
    end
  endtask

  // Whole block with a fixed mode; residuals alternate between two values
  task automatic send_block(input ibr_pkg::mode_e mode, input logic [7:0] even,
                            input logic [7:0] odd);
    for (int p = 0; p < 64; p++)
      send_pixel((p == 0) ? mode : 2'($urandom_range(3)), p[0] ? odd : even);
  endtask

  task automatic send_random(input int unsigned count);
    logic [1:0] cmd;
    logic [7:0] residual;
    for (int i = 0; i < count; i++) begin
      if (trk_pix != 0) cmd = 2'($urandom_range(3));
      else if ($urandom_range(9) == 0) cmd = ibr_pkg::MODE_INVALID;
      else cmd = 2'($urandom_range(2));
      case ($urandom_range(9))
        0:       residual = 8'h00;
        1:       residual = 8'hFF;
        default: residual = 8'($urandom_range(255));
      endcase
      send_pixel(cmd, residual);
    end
  endtask

  task automatic write_reg(input logic index, input logic [6:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == ibr_pkg::CfgBlocksAcross) across_cfg = value;
    else down_cfg = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected pixel, then let the block finish its preparation
  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_count(input int unsigned wide);
    case ($urandom_range(9))
      0:       return 7'd0;
      1:       return 7'($urandom_range(64, 127));
      2:       return 7'($urandom_range(5, wide));
      default: return 7'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int unsigned sent, count;
    logic [6:0]  value;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = ibr_pkg::CfgBlocksAcross;
    cfg_data_i    = '0;
    idle_en       = 1'b1;
    trk_pix       = 0;
    trk_col       = 0;
    trk_line      = 0;
    across_cfg    = ibr_pkg::BlocksAcrossReset;
    down_cfg      = ibr_pkg::BlocksDownReset;
    col_written   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset geometry, top block line: every mode, residual extremes
    send_block(ibr_pkg::MODE_DC, 8'hFF, 8'hFF);
    send_block(ibr_pkg::MODE_HORZ, 8'h00, 8'h00);
    send_block(ibr_pkg::MODE_INVALID, 8'hFF, 8'h00);
    send_block(ibr_pkg::MODE_VERT, 8'h00, 8'hFF);
    s_axis_tvalid <= 1'b0;
    settle();

    // Width 0 acts as 1: current column wraps at once; tall picture
    write_reg(ibr_pkg::CfgBlocksAcross, 7'd0);
    write_reg(ibr_pkg::CfgBlocksDown, 7'd127);
    send_block(ibr_pkg::MODE_VERT, 8'h80, 8'h7F);
    send_block(ibr_pkg::MODE_VERT, 8'h01, 8'hFE);
    send_block(ibr_pkg::MODE_DC, 8'h55, 8'hAA);
    s_axis_tvalid <= 1'b0;
    settle();

    // Height 0 acts as 1: frame ends on this block line
    write_reg(ibr_pkg::CfgBlocksAcross, 7'd2);
    write_reg(ibr_pkg::CfgBlocksDown, 7'd0);
    send_block(ibr_pkg::MODE_HORZ, 8'h80, 8'h80);
    send_block(ibr_pkg::MODE_HORZ, 8'hFF, 8'h01);
    s_axis_tvalid <= 1'b0;
    settle();

    // Width above the maximum, single block line
    write_reg(ibr_pkg::CfgBlocksAcross, 7'd127);
    send_block(ibr_pkg::MODE_DC, 8'h00, 8'h00);
    send_block(ibr_pkg::MODE_INVALID, 8'h12, 8'h34);
    s_axis_tvalid <= 1'b0;
    settle();

    // Random phases with register changes in between, mid-frame and mid-block
    sent = 0;
    while (sent < RandomPixels) begin
      idle_en <= !(sent >= 600 && sent < 1000);
      settle();
      case ($urandom_range(3))
        0: begin
          value = pick_count(16);
          if (across_ok(value)) write_reg(ibr_pkg::CfgBlocksAcross, value);
        end
        1: write_reg(ibr_pkg::CfgBlocksDown, pick_count(8));
        2: begin
          value = pick_count(16);
          if (across_ok(value)) write_reg(ibr_pkg::CfgBlocksAcross, value);
          write_reg(ibr_pkg::CfgBlocksDown, pick_count(8));
        end
        default: ;
      endcase
      count = 64 * $urandom_range(1, 4);
      if ($urandom_range(3) == 0) count += $urandom_range(1, 63);
      send_random(count);
      s_axis_tvalid <= 1'b0;
      sent += count;
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("intra_block_reconstruct test passed");
    end else begin
      $display("intra_block_reconstruct test failed");
    end
    $finish;
  end

endmodule
